[hw/rtl/cpdc_pkg.sv]
// ----------------------------------------------------------------------------
// cpdc_pkg
// Shared types and constants of the cell pixel-doubling checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cpdc_pkg;

  localparam int MAX_SHEET_WIDTH_DEF = 1024;
  localparam int MAX_GRID_COLS_DEF   = 16;
  localparam int PIXEL_BITS_DEF      = 32;

  localparam int PIXEL_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int SIZE_W     = 9;
  localparam int COLS_CFG_W = 5;
  localparam int ROWS_CFG_W = 7;
  localparam int CELL_COL_W = 4;
  localparam int CELL_ROW_W = 6;
  localparam int MAX_ROWS   = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_WIDTH  = 2'd0,
    CFG_CELL_HEIGHT = 2'd1,
    CFG_GRID_COLS   = 2'd2,
    CFG_GRID_ROWS   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [SIZE_W-1:0]     cell_width;
    logic [SIZE_W-1:0]     cell_height;
    logic [COLS_CFG_W-1:0] grid_cols;
    logic [ROWS_CFG_W-1:0] grid_rows;
  } cfg_t;

  typedef struct packed {
    logic                  emit;
    logic                  clr;
    logic                  chk;
    logic                  odd_x;
    logic                  last;
    logic [CELL_ROW_W-1:0] row;
    logic [CELL_COL_W-1:0] col;
  } s1_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/cpdc_if.sv]
// ----------------------------------------------------------------------------
// cpdc_in_if / cpdc_out_if
// Valid/ready channels for pixel requests and cell result requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpdc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_value;
  logic        image_start;

  modport source (output valid, output pixel_value, output image_start, input ready);
  modport sink   (input valid, input pixel_value, input image_start, output ready);
endinterface

interface cpdc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] cell_col;
  logic [5:0] cell_row;
  logic       defective;
  logic       last_cell;

  modport source (output valid, output cell_col, output cell_row, output defective,
                  output last_cell, input ready);
  modport sink   (input valid, input cell_col, input cell_row, input defective,
                  input last_cell, output ready);
endinterface

`default_nettype wire

[hw/rtl/cell_pixel_doubling_checker_core.sv]
// ----------------------------------------------------------------------------
// cell_pixel_doubling_checker_core
// Checks that every aligned 2x2 block of each sprite cell is uniform.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle, set by the single line buffer RAM port pair;
// the input stalls only while a result waits behind a full out_ch. A result
// goes from its bottom-right pixel via the stage 1 and result registers.
// Reset: counters, column flags and valid bits cleared and config set to its
// defaults; line buffer contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_pixel_doubling_checker_core import cpdc_pkg::*; #(
  parameter int MAX_SHEET_WIDTH = MAX_SHEET_WIDTH_DEF,
  parameter int MAX_GRID_COLS   = MAX_GRID_COLS_DEF,
  parameter int PIXEL_BITS      = PIXEL_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  cpdc_in_if.sink                    in_ch,
  cpdc_out_if.source                 out_ch
);

  localparam int PAIR_DEPTH = MAX_SHEET_WIDTH / 2;
  localparam int AW         = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
  localparam int COL_W      = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;

  cfg_t                  cfg_r;
  logic                  s1_v, s1_adv, wr_en, rd_en;
  s1_ctl_t               s1_ctl;
  logic [PIXEL_BITS-1:0] s1_px;
  logic [COL_W-1:0]      s1_fcol;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [PIXEL_BITS:0]   wr_data, rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cell_width  <= SIZE_W'(32);
      cfg_r.cell_height <= SIZE_W'(32);
      cfg_r.grid_cols   <= COLS_CFG_W'(1);
      cfg_r.grid_rows   <= ROWS_CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CELL_WIDTH:  cfg_r.cell_width  <= cfg_data;
        CFG_CELL_HEIGHT: cfg_r.cell_height <= cfg_data;
        CFG_GRID_COLS:   cfg_r.grid_cols   <= cfg_data[COLS_CFG_W-1:0];
        CFG_GRID_ROWS:   cfg_r.grid_rows   <= cfg_data[ROWS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  cpdc_front #(
    .MAX_SHEET_WIDTH (MAX_SHEET_WIDTH),
    .MAX_GRID_COLS   (MAX_GRID_COLS),
    .PIXEL_BITS      (PIXEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .s1_adv    (s1_adv),
    .s1_v_r    (s1_v),
    .s1_ctl_r  (s1_ctl),
    .s1_px_r   (s1_px),
    .s1_fcol_r (s1_fcol),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  cpdc_ram #(
    .WIDTH (PIXEL_BITS + 1),
    .DEPTH (PAIR_DEPTH)
  ) u_pair_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .re      (rd_en),
    .raddr   (rd_addr),
    .rdata_r (rd_data)
  );

  cpdc_back #(
    .MAX_GRID_COLS (MAX_GRID_COLS),
    .PIXEL_BITS    (PIXEL_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .s1_v    (s1_v),
    .s1_ctl  (s1_ctl),
    .s1_px   (s1_px),
    .s1_fcol (s1_fcol),
    .rd_data (rd_data),
    .s1_adv  (s1_adv),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

[hw/rtl/cpdc_ram.sv]
// ----------------------------------------------------------------------------
// cpdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cpdc_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 512,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cpdc_front.sv]
// ----------------------------------------------------------------------------
// cpdc_front
// Raster counters, top-pair line buffer write and read issue, stage 1 register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpdc_front import cpdc_pkg::*; #(
  parameter int MAX_SHEET_WIDTH = MAX_SHEET_WIDTH_DEF,
  parameter int MAX_GRID_COLS   = MAX_GRID_COLS_DEF,
  parameter int PIXEL_BITS      = PIXEL_BITS_DEF,
  localparam int PAIR_DEPTH     = MAX_SHEET_WIDTH / 2,
  localparam int AW             = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1,
  localparam int COL_W          = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cfg_t                  cfg,
  cpdc_in_if.sink                    in_ch,
  input  wire logic                  s1_adv,
  output logic                       s1_v_r,
  output s1_ctl_t                    s1_ctl_r,
  output logic [PIXEL_BITS-1:0]      s1_px_r,
  output logic [COL_W-1:0]           s1_fcol_r,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [PIXEL_BITS:0]        wr_data,
  output logic                       rd_en,
  output logic [AW-1:0]              rd_addr
);

  localparam int PX_W  = $clog2(MAX_SHEET_WIDTH);
  localparam int CNT_W = $clog2(MAX_GRID_COLS + 1);

  function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] e;
    e = {v[SIZE_W-1:1], 1'b0};
    if (e == '0) begin
      return SIZE_W'(2);
    end
    if (e > SIZE_W'(256)) begin
      return SIZE_W'(256);
    end
    return e;
  endfunction

  logic [PX_W-1:0]       px_x_r, px_x_nxt, cur_px_x;
  logic [7:0]            x_r, x_nxt, cur_x;
  logic [7:0]            y_r, y_nxt, cur_y;
  logic [COL_W-1:0]      col_r, col_nxt, cur_col;
  logic [CELL_ROW_W-1:0] row_r, row_nxt, cur_row;
  logic [PIXEL_BITS-1:0] left_r, left_nxt, cur_left;

  logic                  accept, start, even_row, odd_x, emit, last;
  logic [PIXEL_BITS-1:0] px;
  logic [SIZE_W-1:0]     cw, ch, x_inc, y_inc;
  logic [CNT_W-1:0]      cols_e, col_inc;
  logic [ROWS_CFG_W-1:0] rows_e, row_inc;
  logic [PX_W:0]         px_x_inc;
  logic [PX_W-2:0]       idx_full;
  logic [AW-1:0]         idx;

  assign in_ch.ready = !s1_v_r || s1_adv;
  assign accept      = in_ch.valid && in_ch.ready;
  assign start       = in_ch.image_start;
  assign px          = in_ch.pixel_value[PIXEL_BITS-1:0];

  always_comb begin
    cw = eff_size(cfg.cell_width);
    ch = eff_size(cfg.cell_height);

    if (cfg.grid_cols == '0) begin
      cols_e = CNT_W'(1);
    end else if (int'(cfg.grid_cols) > MAX_GRID_COLS) begin
      cols_e = CNT_W'(MAX_GRID_COLS);
    end else begin
      cols_e = CNT_W'(cfg.grid_cols);
    end

    if (cfg.grid_rows == '0) begin
      rows_e = ROWS_CFG_W'(1);
    end else if (cfg.grid_rows > ROWS_CFG_W'(MAX_ROWS)) begin
      rows_e = ROWS_CFG_W'(MAX_ROWS);
    end else begin
      rows_e = cfg.grid_rows;
    end

    cur_px_x = start ? '0 : px_x_r;
    cur_x    = start ? '0 : x_r;
    cur_y    = start ? '0 : y_r;
    cur_col  = start ? '0 : col_r;
    cur_row  = start ? '0 : row_r;
    cur_left = start ? '0 : left_r;

    idx_full = cur_px_x[PX_W-1:1];
    idx      = (int'(idx_full) >= PAIR_DEPTH) ? '0 : AW'(idx_full);
    even_row = !cur_y[0];
    odd_x    = cur_px_x[0];

    left_nxt = (even_row && !odd_x) ? px : cur_left;
    wr_en    = accept && even_row && odd_x;
    wr_addr  = idx;
    wr_data  = {px != cur_left, cur_left};
    rd_en    = accept;
    rd_addr  = idx;

    emit = ({1'b0, cur_x} == cw - SIZE_W'(1)) && ({1'b0, cur_y} == ch - SIZE_W'(1));
    last = (CNT_W'(cur_col) == cols_e - CNT_W'(1)) &&
           ({1'b0, cur_row} == rows_e - ROWS_CFG_W'(1));

    x_inc    = {1'b0, cur_x} + SIZE_W'(1);
    y_inc    = {1'b0, cur_y} + SIZE_W'(1);
    col_inc  = CNT_W'(cur_col) + CNT_W'(1);
    row_inc  = {1'b0, cur_row} + ROWS_CFG_W'(1);
    px_x_inc = {1'b0, cur_px_x} + (PX_W+1)'(1);

    px_x_nxt = (int'(px_x_inc) >= MAX_SHEET_WIDTH) ? '0 : PX_W'(px_x_inc);
    x_nxt    = x_inc[7:0];
    y_nxt    = cur_y;
    col_nxt  = cur_col;
    row_nxt  = cur_row;
    if (x_inc >= cw) begin
      x_nxt = '0;
      if (col_inc >= cols_e) begin
        col_nxt  = '0;
        px_x_nxt = '0;
        if (y_inc >= ch) begin
          y_nxt = '0;
          row_nxt = (row_inc >= rows_e) ? '0 : row_inc[CELL_ROW_W-1:0];
        end else begin
          y_nxt = y_inc[7:0];
        end
      end else begin
        col_nxt = COL_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_x_r <= '0;
      x_r    <= '0;
      y_r    <= '0;
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (accept) begin
        px_x_r <= px_x_nxt;
        x_r    <= x_nxt;
        y_r    <= y_nxt;
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        left_r <= left_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r.emit  <= emit;
      s1_ctl_r.clr   <= start;
      s1_ctl_r.chk   <= !even_row;
      s1_ctl_r.odd_x <= odd_x;
      s1_ctl_r.last  <= last;
      s1_ctl_r.row   <= cur_row;
      s1_ctl_r.col   <= CELL_COL_W'(cur_col);
      s1_px_r        <= px;
      s1_fcol_r      <= cur_col;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cpdc_back.sv]
// ----------------------------------------------------------------------------
// cpdc_back
// Bottom-pair compare, per-column defect flags and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpdc_back import cpdc_pkg::*; #(
  parameter int MAX_GRID_COLS = MAX_GRID_COLS_DEF,
  parameter int PIXEL_BITS    = PIXEL_BITS_DEF,
  localparam int COL_W        = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  s1_v,
  input  wire s1_ctl_t               s1_ctl,
  input  wire logic [PIXEL_BITS-1:0] s1_px,
  input  wire logic [COL_W-1:0]      s1_fcol,
  input  wire logic [PIXEL_BITS:0]   rd_data,
  output logic                       s1_adv,
  cpdc_out_if.source                 out_ch
);

  logic [MAX_GRID_COLS-1:0] flags_r, flags_nxt, flags_base;
  logic                     bad, flag_cur, out_v_r, out_free;
  logic                     def_r, last_r;
  logic [CELL_COL_W-1:0]    col_r;
  logic [CELL_ROW_W-1:0]    row_r;

  assign out_free = !out_v_r || out_ch.ready;
  assign s1_adv   = s1_v && (!s1_ctl.emit || out_free);

  always_comb begin
    bad = s1_ctl.chk && ((s1_px != rd_data[PIXEL_BITS-1:0]) ||
                         (s1_ctl.odd_x && rd_data[PIXEL_BITS]));
    flags_base         = s1_ctl.clr ? '0 : flags_r;
    flag_cur           = flags_base[s1_fcol] | bad;
    flags_nxt          = flags_base;
    flags_nxt[s1_fcol] = s1_ctl.emit ? 1'b0 : flag_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        flags_r <= flags_nxt;
      end
      if (s1_adv && s1_ctl.emit) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctl.emit) begin
      col_r  <= s1_ctl.col;
      row_r  <= s1_ctl.row;
      def_r  <= flag_cur;
      last_r <= s1_ctl.last;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.cell_col  = col_r;
  assign out_ch.cell_row  = row_r;
  assign out_ch.defective = def_r;
  assign out_ch.last_cell = last_r;

endmodule

`default_nettype wire

[sim/tb_cell_pixel_doubling_checker_core.sv]
// ----------------------------------------------------------------------------
// tb_cell_pixel_doubling_checker_core
// Streams sprite-sheet pixels through the checker and compares every cell
// result against a hand-set verdict or a cycle-free predictor of the 2x2
// doubling rule. A short table of hand-checked sheets comes first. Full
// sheets at the extreme cell and grid sizes follow, and then random sheets
// with mostly doubled artwork, sparse defects, noisy and cut-short sheets.
// Both channels idle at random.

module tb_cell_pixel_doubling_checker_core import cpdc_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAIR_DEPTH    = MAX_SHEET_WIDTH_DEF / 2;
  localparam int MAX_BLOCKS    = 256 * MAX_GRID_COLS_DEF / 2;
  localparam int RANDOM_PIXELS = 200;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    logic [CELL_COL_W-1:0] cell_col;
    logic [CELL_ROW_W-1:0] cell_row;
    logic                  defective;
    logic                  last_cell;
  } cell_verdict_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               start;
    logic               typed;
    logic               has_verdict;
    cell_verdict_t      verdict;
  } directed_row_t;

  localparam cell_verdict_t NO_VERDICT = '0;

  // 2x2 cells, 2x1 grid: a clean sheet, a wrapped sheet with defects
  // (predicted), then a restart that clears a raised column flag.
  localparam directed_row_t DIRECTED_ROWS [27] = '{
    '{32'h0000_0000, 1'b1, 1'b1, 1'b0, NO_VERDICT},
    '{32'h0000_0000, 1'b0, 1'b1, 1'b0, NO_VERDICT},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, NO_VERDICT},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, NO_VERDICT},
    '{32'h0000_0000, 1'b0, 1'b1, 1'b0, NO_VERDICT},
    '{32'h0000_0000, 1'b0, 1'b1, 1'b1, '{4'd0, 6'd0, 1'b0, 1'b0}},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, NO_VERDICT},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, '{4'd1, 6'd0, 1'b0, 1'b1}},
    '{32'h1234_5678, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{32'h1234_5679, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{32'hA5A5_A5A5, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{32'hA5A5_A5A5, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{32'h1234_5678, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{32'h1234_5678, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{32'hA5A5_A5A5, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{32'h5A5A_5A5A, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{32'h0000_0007, 1'b0, 1'b1, 1'b0, NO_VERDICT},
    '{32'h0000_0007, 1'b0, 1'b1, 1'b0, NO_VERDICT},
    '{32'h0000_0007, 1'b0, 1'b1, 1'b0, NO_VERDICT},
    '{32'h0000_0007, 1'b0, 1'b1, 1'b0, NO_VERDICT},
    '{32'h0000_0008, 1'b0, 1'b1, 1'b0, NO_VERDICT},
    '{32'h0000_0009, 1'b1, 1'b1, 1'b0, NO_VERDICT},
    '{32'h0000_0009, 1'b0, 1'b1, 1'b0, NO_VERDICT},
    '{32'h0000_0009, 1'b0, 1'b1, 1'b0, NO_VERDICT},
    '{32'h0000_0009, 1'b0, 1'b1, 1'b0, NO_VERDICT},
    '{32'h0000_0009, 1'b0, 1'b1, 1'b0, NO_VERDICT},
    '{32'h0000_0009, 1'b0, 1'b1, 1'b1, '{4'd0, 6'd0, 1'b0, 1'b0}}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cpdc_in_if  in_ch ();
  cpdc_out_if out_ch ();

  cell_pixel_doubling_checker_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  logic [SIZE_W-1:0]     grid_cell_w;
  logic [SIZE_W-1:0]     grid_cell_h;
  logic [COLS_CFG_W-1:0] grid_cols_raw;
  logic [ROWS_CFG_W-1:0] grid_rows_raw;

  logic [PIXEL_W-1:0] top_pixel [PAIR_DEPTH];
  bit                 top_bad [PAIR_DEPTH];
  bit                 column_flag [MAX_GRID_COLS_DEF];
  logic [PIXEL_W-1:0] left_px;
  int unsigned        sheet_x, cell_x, cell_y, row_cnt, col_cnt;

  bit [PIXEL_W-1:0]   block_color [MAX_BLOCKS];
  cell_verdict_t      pending_verdicts [$];

  int fails;
  int pixels_sent;
  int random_pixels;
  int verdicts_seen;
  int defects_seen;
  int grid_settings;
  bit idle_on;
  bit stalls_on;
  bit long_hold_req;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int unsigned eff_size(input logic [SIZE_W-1:0] raw);
    logic [SIZE_W-1:0] rounded;
    rounded = raw & 9'h1FE;
    if (rounded == 0) return 2;
    if (rounded > 256) return 256;
    return 32'(rounded);
  endfunction

  function automatic int unsigned eff_cols();
    if (grid_cols_raw == 0) return 1;
    if (grid_cols_raw > MAX_GRID_COLS_DEF) return MAX_GRID_COLS_DEF;
    return 32'(grid_cols_raw);
  endfunction

  function automatic int unsigned eff_rows();
    if (grid_rows_raw == 0) return 1;
    if (grid_rows_raw > MAX_ROWS) return MAX_ROWS;
    return 32'(grid_rows_raw);
  endfunction

  function automatic void clear_sheet_state();
    foreach (column_flag[i]) column_flag[i] = 1'b0;
    left_px = '0;
    sheet_x = 0;
    cell_x  = 0;
    cell_y  = 0;
    row_cnt = 0;
    col_cnt = 0;
  endfunction

  function automatic bit predict_cell_verdict(input logic [PIXEL_W-1:0] px, input logic st,
                                              output cell_verdict_t verdict);
    int unsigned cw, ch, cols, rows, slot, fcol;
    bit bad;
    bit emitted;
    cw      = eff_size(grid_cell_w);
    ch      = eff_size(grid_cell_h);
    cols    = eff_cols();
    rows    = eff_rows();
    verdict = NO_VERDICT;
    bad     = 1'b0;
    emitted = 1'b0;
    if (st) clear_sheet_state();
    slot = (sheet_x / 2) % PAIR_DEPTH;
    fcol = col_cnt % MAX_GRID_COLS_DEF;
    if (cell_y % 2 == 0) begin
      if (sheet_x % 2 == 0) begin
        left_px = px;
      end else begin
        top_pixel[slot] = left_px;
        top_bad[slot]   = (px != left_px);
      end
    end else begin
      bad = (px != top_pixel[slot]);
      if (sheet_x % 2 == 1) bad = bad || top_bad[slot];
    end
    if (bad) column_flag[fcol] = 1'b1;
    if (cell_x == cw - 1 && cell_y == ch - 1) begin
      verdict.cell_col  = col_cnt[CELL_COL_W-1:0];
      verdict.cell_row  = row_cnt[CELL_ROW_W-1:0];
      verdict.defective = column_flag[fcol];
      verdict.last_cell = (col_cnt == cols - 1 && row_cnt == rows - 1);
      column_flag[fcol] = 1'b0;
      emitted = 1'b1;
    end
    cell_x++;
    sheet_x++;
    if (sheet_x >= MAX_SHEET_WIDTH_DEF) sheet_x = 0;
    if (cell_x >= cw) begin
      cell_x = 0;
      col_cnt++;
      if (col_cnt >= cols) begin
        col_cnt = 0;
        sheet_x = 0;
        cell_y++;
        if (cell_y >= ch) begin
          cell_y = 0;
          row_cnt++;
          if (row_cnt >= rows) row_cnt = 0;
        end
      end
    end
    return emitted;
  endfunction

  task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic st, input bit typed,
                            input bit typed_has, input cell_verdict_t typed_verdict);
    cell_verdict_t predicted;
    bit emitted;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.pixel_value <= px;
    in_ch.image_start <= st;
    do @(posedge clk); while (!in_ch.ready);
    pixels_sent++;
    emitted = predict_cell_verdict(px, st, predicted);
    if (typed) begin
      if (typed_has) pending_verdicts.push_back(typed_verdict);
    end else if (emitted) begin
      pending_verdicts.push_back(predicted);
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic apply_grid(input logic [SIZE_W-1:0] cw, input logic [SIZE_W-1:0] ch,
                            input logic [COLS_CFG_W-1:0] cols,
                            input logic [ROWS_CFG_W-1:0] rows);
    write_reg(CFG_CELL_WIDTH, cw);
    write_reg(CFG_CELL_HEIGHT, ch);
    write_reg(CFG_GRID_COLS, CFG_DATA_W'(cols));
    write_reg(CFG_GRID_ROWS, CFG_DATA_W'(rows));
    cfg_we <= 1'b0;
    grid_cell_w   = cw;
    grid_cell_h   = ch;
    grid_cols_raw = cols;
    grid_rows_raw = rows;
    grid_settings++;
  endtask

  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_sheet(input bit with_start, input bit broken, input bit noisy);
    int unsigned w, h, total, stop, x, y;
    logic [PIXEL_W-1:0] px;
    w     = eff_size(grid_cell_w) * eff_cols();
    h     = eff_size(grid_cell_h) * eff_rows();
    total = w * h;
    stop  = broken ? $urandom_range(1, total - 1) : total;
    for (int unsigned i = 0; i < stop; i++) begin
      x = i % w;
      y = i / w;
      if (y % 2 == 0 && x % 2 == 0 && $urandom_range(0, 2) != 0)
        block_color[x / 2] = $urandom;
      px = noisy ? PIXEL_W'($urandom) : block_color[x / 2];
      if ($urandom_range(0, 39) == 0) px = px ^ (32'h1 << $urandom_range(0, 31));
      send_pixel(px, with_start && i == 0, 1'b0, 1'b0, NO_VERDICT);
    end
  endtask

  always @(posedge clk) begin : result_check
    cell_verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      verdicts_seen++;
      if (out_ch.defective) defects_seen++;
      if (pending_verdicts.size() == 0) begin
        $error("unexpected cell result: col %0d row %0d", out_ch.cell_col, out_ch.cell_row);
        fails++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_ch.cell_col !== want.cell_col) begin
          $error("cell_col: expected %0d, got %0d", want.cell_col, out_ch.cell_col);
          fails++;
        end
        if (out_ch.cell_row !== want.cell_row) begin
          $error("cell_row: expected %0d, got %0d", want.cell_row, out_ch.cell_row);
          fails++;
        end
        if (out_ch.defective !== want.defective) begin
          $error("defective: expected %0b, got %0b", want.defective, out_ch.defective);
          fails++;
        end
        if (out_ch.last_cell !== want.last_cell) begin
          $error("last_cell: expected %0b, got %0b", want.last_cell, out_ch.last_cell);
          fails++;
        end
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #1_000_000;
    $display("timeout with %0d cell results outstanding", pending_verdicts.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int phase_pixels;
    int sheets;
    int mark;
    bit restart_needed;
    bit broken;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_CELL_WIDTH;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.pixel_value = '0;
    in_ch.image_start = 1'b0;
    idle_on           = 1'b1;
    stalls_on         = 1'b1;
    long_hold_req     = 1'b0;
    grid_cell_w       = 9'd32;
    grid_cell_h       = 9'd32;
    grid_cols_raw     = 5'd1;
    grid_rows_raw     = 7'd1;
    clear_sheet_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apply_grid(9'd2, 9'd2, 5'd2, 7'd1);
    foreach (DIRECTED_ROWS[i])
      send_pixel(DIRECTED_ROWS[i].pixel, DIRECTED_ROWS[i].start, DIRECTED_ROWS[i].typed,
                 DIRECTED_ROWS[i].has_verdict, DIRECTED_ROWS[i].verdict);
    settle_block();

    // zero cell sizes and grid counts out of range
    apply_grid(9'd0, 9'd0, 5'd0, 7'd127);
    run_sheet(1'b1, 1'b0, 1'b0);
    settle_block();
    apply_grid(9'd2, 9'd2, 5'd31, 7'd0);
    run_sheet(1'b1, 1'b0, 1'b0);

    phase = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      settle_block();
      if (phase == 0) begin
        apply_grid(9'd2, 9'd2, 5'd2, 7'd2);
        long_hold_req = 1'b1;
      end else begin
        apply_grid(SIZE_W'($urandom_range(0, 5)), SIZE_W'($urandom_range(0, 5)),
                   COLS_CFG_W'($urandom_range(0, 3)), ROWS_CFG_W'($urandom_range(0, 2)));
      end
      phase_pixels   = 0;
      sheets         = 0;
      restart_needed = 1'b1;
      while (phase_pixels < 60 && random_pixels < RANDOM_PIXELS) begin
        mark   = pixels_sent;
        broken = ($urandom_range(0, 7) == 0);
        run_sheet(restart_needed || $urandom_range(0, 3) != 0, broken,
                  $urandom_range(0, 9) == 0);
        restart_needed = broken;
        sheets++;
        phase_pixels  += pixels_sent - mark;
        random_pixels += pixels_sent - mark;
        if (phase == 0 && sheets == 1) settle_block();
        if (random_pixels > RANDOM_PIXELS - 80) begin
          idle_on   = 1'b0;
          stalls_on = 1'b0;
        end
      end
      phase++;
    end
    settle_block();

    $display("Sent %0d pixel requests under %0d grid settings, %0d in random sheets.",
             pixels_sent, grid_settings, random_pixels);
    $display("Checked %0d cell results, %0d of them flagged defective.",
             verdicts_seen, defects_seen);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/cpdc_pkg.sv
hw/rtl/cpdc_if.sv
hw/rtl/cpdc_ram.sv
hw/rtl/cpdc_front.sv
hw/rtl/cpdc_back.sv
hw/rtl/cell_pixel_doubling_checker_core.sv
sim/tb_cell_pixel_doubling_checker_core.sv
